// File: design/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; compile first.
`default_nettype none

package mbps_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int ADDR_W       = 48;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_INDEX_W  = 2;
	localparam int PAT_BYTES    = 16;
	localparam int PAT_W        = 8 * PAT_BYTES;
	localparam int OFS_W        = 4;
	localparam int LEN_CFG_W    = 5;
	localparam int QUEUE_DEPTH  = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PAT_LO  = 2'd0,
		REG_PAT_HI  = 2'd1,
		REG_CMP_EN  = 2'd2,
		REG_PAT_LEN = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
		logic [OFS_W-1:0]  offset;
	} result_t;

endpackage

`default_nettype wire

// File: design/mbps_if.sv
// Valid/ready channel interfaces for scanner input bytes and scan results.
// Depends on mbps_pkg.
`default_nettype none

interface mbps_in_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  data_byte;
	logic [mbps_pkg::ADDR_W-1:0] byte_address;
	logic                        region_start;
	logic                        scan_end;

	modport source (output valid, data_byte, byte_address, region_start, scan_end,
		input ready);
	modport sink (input valid, data_byte, byte_address, region_start, scan_end,
		output ready);
endinterface

interface mbps_out_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [mbps_pkg::ADDR_W-1:0] match_address;

	modport source (output valid, found, match_address, input ready);
	modport sink (input valid, found, match_address, output ready);
endinterface

`default_nettype wire

// File: design/mbps_front.sv
// Front end: configuration registers, byte window, masked compare and scan state.
// Classifies each accepted byte and pushes at most one result. Depends on mbps_pkg, mbps_if.
`default_nettype none

module mbps_front #(
	parameter int PATTERN_MAX = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	mbps_in_if.sink                                  in_ch,
	input  wire logic                                cfg_write,
	input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                q_full,
	output logic                                     push,
	output mbps_pkg::result_t                        push_data
);

	localparam int MAXLEN = (PATTERN_MAX < mbps_pkg::WINDOW_DEPTH) ?
		PATTERN_MAX : mbps_pkg::WINDOW_DEPTH;
	localparam int FILL_W = $clog2(MAXLEN + 1);

	logic [mbps_pkg::PAT_W-1:0]      pat_q;
	logic [mbps_pkg::PAT_BYTES-1:0]  cmp_en_q;
	logic [mbps_pkg::LEN_CFG_W-1:0]  len_cfg_q;
	logic [7:0]                      win_q [MAXLEN];
	logic [7:0]                      win_nxt [MAXLEN];
	logic [FILL_W-1:0]               fill_q;
	logic [FILL_W-1:0]               fill_base;
	logic [FILL_W-1:0]               fill_nxt;
	logic                            done_q;
	logic [FILL_W-1:0]               eff_len;
	logic                            cmp_ok;
	logic                            match;
	logic                            accept;
	logic [mbps_pkg::OFS_W-1:0]      pidx;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= '0;
			cmp_en_q  <= '0;
			len_cfg_q <= mbps_pkg::LEN_CFG_W'(1);
		end else if (cfg_write) begin
			unique case (mbps_pkg::cfg_reg_t'(cfg_index))
				mbps_pkg::REG_PAT_LO:  pat_q[63:0]   <= cfg_data;
				mbps_pkg::REG_PAT_HI:  pat_q[127:64] <= cfg_data;
				mbps_pkg::REG_CMP_EN:  cmp_en_q      <= cfg_data[15:0];
				mbps_pkg::REG_PAT_LEN: len_cfg_q     <= cfg_data[mbps_pkg::LEN_CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (len_cfg_q == '0) begin
			eff_len = FILL_W'(1);
		end else if (len_cfg_q > mbps_pkg::LEN_CFG_W'(MAXLEN)) begin
			eff_len = FILL_W'(MAXLEN);
		end else begin
			eff_len = FILL_W'(len_cfg_q);
		end
	end

	always_comb begin
		win_nxt[0] = in_ch.data_byte;
		for (int k = 1; k < MAXLEN; k++) begin
			win_nxt[k] = win_q[k-1];
		end
	end

	always_comb begin
		cmp_ok = 1'b1;
		pidx   = '0;
		for (int k = 0; k < MAXLEN; k++) begin
			pidx = mbps_pkg::OFS_W'(32'(eff_len) - 32'(k) - 32'd1);
			if (k < 32'(eff_len) && cmp_en_q[pidx] &&
				win_nxt[k] != pat_q[8*pidx +: 8]) begin
				cmp_ok = 1'b0;
			end
		end
	end

	always_comb begin
		fill_base = in_ch.region_start ? '0 : fill_q;
		fill_nxt  = (fill_base < FILL_W'(MAXLEN)) ? fill_base + FILL_W'(1) : fill_base;
	end

	assign match = !done_q && (fill_nxt >= eff_len) && cmp_ok;
	assign push  = accept && (match || (in_ch.scan_end && !done_q));

	always_comb begin
		push_data.found  = match;
		push_data.addr   = match ? in_ch.byte_address : '0;
		push_data.offset = match ? mbps_pkg::OFS_W'(eff_len - FILL_W'(1)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
			for (int k = 0; k < MAXLEN; k++) begin
				win_q[k] <= '0;
			end
		end else if (accept) begin
			win_q  <= win_nxt;
			fill_q <= in_ch.scan_end ? '0 : fill_nxt;
			done_q <= in_ch.scan_end ? 1'b0 : (done_q || match);
		end
	end

	a_scan_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.scan_end |=> fill_q == '0 && !done_q)
		else $error("scan state not cleared after scan end");

endmodule

`default_nettype wire

// File: design/mbps_queue.sv
// Short result queue between front end and output stage.
// Depends on mbps_pkg.
`default_nettype none

module mbps_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire mbps_pkg::result_t  push_data,
	input  wire logic               pop,
	output mbps_pkg::result_t       pop_data,
	output logic                    full,
	output logic                    empty
);

	localparam int PTR_W = (mbps_pkg::QUEUE_DEPTH > 1) ? $clog2(mbps_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(mbps_pkg::QUEUE_DEPTH + 1);

	mbps_pkg::result_t   mem_q [mbps_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_q;
	logic [PTR_W-1:0]    rd_q;
	logic [CNT_W-1:0]    cnt_q;

	assign full     = cnt_q == CNT_W'(mbps_pkg::QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(mbps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(mbps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: design/mbps_back.sv
// Back end: forms the match address and holds the result register on the output channel.
// Depends on mbps_pkg, mbps_if.
`default_nettype none

module mbps_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire mbps_pkg::result_t  q_data,
	output logic                    pop,
	mbps_out_if.source              out_ch
);

	logic                        valid_q;
	logic                        found_q;
	logic [mbps_pkg::ADDR_W-1:0] addr_q;

	assign pop = !q_empty && (!valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			found_q <= q_data.found;
			addr_q  <= q_data.found ?
				q_data.addr - mbps_pkg::ADDR_W'(q_data.offset) : '0;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.found         = found_q;
	assign out_ch.match_address = addr_q;

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !found_q |-> addr_q == '0)
		else $error("not-found result carries nonzero address");

endmodule

`default_nettype wire

// File: design/masked_byte_pattern_scanner_core.sv
// Masked byte pattern scanner, top level.
// Depends on mbps_pkg, mbps_if, mbps_front, mbps_queue, mbps_back.
//
// Usage:
//   in_ch carries one memory byte per transfer with its address, a region-start
//   flag and a scan-end flag. out_ch carries at most one result per scan: found
//   with the address of the match's first byte, or not-found on the scan-end byte.
//   cfg_write/cfg_index/cfg_data write the pattern, compare enables and length;
//   write only while no result is pending.
// Throughput: one byte per cycle while the result queue has room; the masked compare
//   of the whole window is combinational in the front end.
// Result path: the front end writes the queue at the byte's transfer edge and the
//   back end loads the output register from the queue once that register is empty
//   or its result is being taken, which sets out_ch.valid.
// Stall: a two-entry result queue decouples the front end; in_ch.ready drops
//   only while both entries are held because out_ch is not taking results.
// Reset: arst_n clears the window, fill count, scan state, queue and output
//   valid; pattern registers return to zero and length to one.
`default_nettype none

module masked_byte_pattern_scanner_core #(
	parameter int PATTERN_MAX = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	mbps_in_if.sink                               in_ch,
	mbps_out_if.source                            out_ch,
	input  wire logic                             cfg_write,
	input  wire logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	mbps_pkg::result_t push_data;
	mbps_pkg::result_t pop_data;

	mbps_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	mbps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	mbps_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (pop_data),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

// File: test/scan_checker.sv
// Scoreboard for the masked byte pattern scanner: watches the byte, result and register
// ports, predicts each scan result and compares it with what the block delivers.
// Depends on mbps_pkg and the channel interfaces in mbps_if.
module scan_checker #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mbps_in_if                               in_mon,
	mbps_out_if                              out_mon,
	input  logic                             cfg_write,
	input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               fail_count,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_LEN = (PATTERN_MAX < mbps_pkg::WINDOW_DEPTH) ? PATTERN_MAX
		: mbps_pkg::WINDOW_DEPTH;

	typedef struct packed {
		logic                        found;
		logic [mbps_pkg::ADDR_W-1:0] addr;
	} scan_result_t;

	scan_result_t               awaited_results[$];
	logic [mbps_pkg::PAT_W-1:0] pattern;
	logic [15:0]                cmp_mask;
	logic [4:0]                 len_code;
	logic [7:0]                 window[mbps_pkg::WINDOW_DEPTH];
	int                         fill;
	logic                       done;
	int                         fails;

	function automatic int active_length(input logic [4:0] code);
		int n;
		n = int'(code);
		if (n == 0)
			n = 1;
		if (n > MAX_LEN)
			n = MAX_LEN;
		return n;
	endfunction

	task automatic step_scan(input logic [7:0] d, input logic [mbps_pkg::ADDR_W-1:0] a,
		input logic rs, input logic se);
		int           len;
		logic         hit;
		scan_result_t res;
		len = active_length(len_code);
		if (rs)
			fill = 0;
		for (int k = mbps_pkg::WINDOW_DEPTH - 1; k > 0; k--)
			window[k] = window[k-1];
		window[0] = d;
		if (fill < MAX_LEN)
			fill++;
		if (!done) begin
			hit = (fill >= len);
			for (int j = 0; j < len; j++)
				if (cmp_mask[j] && window[len-1-j] != pattern[8*j +: 8])
					hit = 1'b0;
			if (hit) begin
				res.found = 1'b1;
				res.addr  = a - mbps_pkg::ADDR_W'(len - 1);
				awaited_results.push_back(res);
				done = 1'b1;
			end else if (se) begin
				res = '0;
				awaited_results.push_back(res);
			end
		end
		if (se) begin
			done = 1'b0;
			fill = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		scan_result_t exp_res;
		if (!arst_n) begin
			awaited_results.delete();
			pattern  = '0;
			cmp_mask = '0;
			len_code = 5'd1;
			for (int k = 0; k < mbps_pkg::WINDOW_DEPTH; k++)
				window[k] = 8'h00;
			fill  = 0;
			done  = 1'b0;
			fails = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result: found %0b match_address %h",
						out_mon.found, out_mon.match_address);
					fails++;
				end else begin
					exp_res = awaited_results.pop_front();
					if (out_mon.found !== exp_res.found) begin
						$error("found: expected %0b actual %0b", exp_res.found, out_mon.found);
						fails++;
					end
					if (out_mon.match_address !== exp_res.addr) begin
						$error("match_address: expected %h actual %h", exp_res.addr,
							out_mon.match_address);
						fails++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				step_scan(in_mon.data_byte, in_mon.byte_address, in_mon.region_start,
					in_mon.scan_end);
			if (cfg_write) begin
				unique case (mbps_pkg::cfg_reg_t'(cfg_index))
					mbps_pkg::REG_PAT_LO: pattern[63:0] = cfg_data;
					mbps_pkg::REG_PAT_HI: pattern[127:64] = cfg_data;
					mbps_pkg::REG_CMP_EN: cmp_mask = cfg_data[15:0];
					mbps_pkg::REG_PAT_LEN: len_code = cfg_data[4:0];
				endcase
			end
			fail_count  <= fails;
			outstanding <= awaited_results.size();
		end
	end

endmodule

// File: test/tb_top.sv
// Top of the scanner testbench: clock, reset, register programming, directed and random
// byte streams with bursty input and stalling output. Depends on mbps_pkg, mbps_if,
// scan_checker and masked_byte_pattern_scanner_core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PATTERN_MAX  = 16;
	localparam int MAX_LEN      = (PATTERN_MAX < mbps_pkg::WINDOW_DEPTH) ? PATTERN_MAX
		: mbps_pkg::WINDOW_DEPTH;
	localparam int ITEM_TARGET  = 1900;
	localparam int IDLE_LIMIT   = 5000;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_write;
	logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data;
	int                               fail_count;
	int                               outstanding;

	mbps_in_if  in_ch();
	mbps_out_if out_ch();

	masked_byte_pattern_scanner_core #(
		.PATTERN_MAX(PATTERN_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	scan_checker #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	logic [mbps_pkg::PAT_W-1:0] pat_mirror;
	logic [15:0]                cmp_mirror;
	int                         len_mirror;
	int                         burst_left;
	int                         bytes_sent;
	int                         idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// output stall pattern: always ready, coin flip, mostly stalled, periodic
	initial begin
		int mode;
		int mode_left;
		int tick;
		out_ch.ready <= 1'b0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(5, 200);
			end
			mode_left--;
			tick++;
			case (mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= 1'($urandom_range(0, 1));
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= ((tick & 7) < 5);
			endcase
			@(posedge clk);
		end
	end

	function automatic int active_length(input logic [4:0] code);
		int n;
		n = int'(code);
		if (n == 0)
			n = 1;
		if (n > MAX_LEN)
			n = MAX_LEN;
		return n;
	endfunction

	function automatic logic [63:0] rand64();
		return {32'($urandom), 32'($urandom)};
	endfunction

	task automatic push_byte(input logic [7:0] d, input logic [mbps_pkg::ADDR_W-1:0] a,
		input logic rs, input logic se);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid        <= 1'b1;
		in_ch.data_byte    <= d;
		in_ch.byte_address <= a;
		in_ch.region_start <= rs;
		in_ch.scan_end     <= se;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// hold input until every pending result has been taken
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
		input logic [63:0] cmp, input logic [63:0] len);
		quiesce();
		cfg_write <= 1'b1;
		cfg_index <= mbps_pkg::REG_PAT_LO;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= mbps_pkg::REG_PAT_HI;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= mbps_pkg::REG_CMP_EN;
		cfg_data  <= cmp;
		@(posedge clk);
		cfg_index <= mbps_pkg::REG_PAT_LEN;
		cfg_data  <= len;
		@(posedge clk);
		cfg_write <= 1'b0;
		pat_mirror = {hi, lo};
		cmp_mirror = cmp[15:0];
		len_mirror = active_length(len[4:0]);
	endtask

	task automatic program_random();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] cmp;
		logic [4:0]  len;
		case ($urandom_range(0, 5))
			0: begin lo = '0; hi = '0; end
			1: begin lo = '1; hi = '1; end
			default: begin lo = rand64(); hi = rand64(); end
		endcase
		case ($urandom_range(0, 5))
			0: cmp = 16'h0000;
			1: cmp = 16'hFFFF;
			default: cmp = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: len = 5'd0;
			1: len = 5'd16;
			2: len = 5'($urandom_range(17, 31));
			3: len = 5'd1;
			default: len = 5'($urandom_range(1, 6));
		endcase
		program_regs(lo, hi, {48'(rand64()), cmp}, {59'(rand64()), len});
	endtask

	function automatic logic [7:0] filler_byte(input int amode);
		case (amode)
			0: return 8'($urandom);
			1: return pat_mirror[8*$urandom_range(0, len_mirror - 1) +: 8];
			default: begin
				case ($urandom_range(0, 2))
					0: return 8'h00;
					1: return 8'hFF;
					default: return pat_mirror[8*$urandom_range(0, len_mirror - 1) +: 8];
				endcase
			end
		endcase
	endfunction

	task automatic run_scan();
		int                          nreg;
		int                          rlen;
		int                          amode;
		int                          ofs;
		int                          j;
		logic [7:0]                  rbytes[64];
		logic [mbps_pkg::ADDR_W-1:0] base;
		logic [mbps_pkg::ADDR_W-1:0] a;
		logic                        rs;
		logic                        se;
		nreg = $urandom_range(1, 3);
		amode = $urandom_range(0, 2);
		for (int r = 0; r < nreg; r++) begin
			if (r > 0 && $urandom_range(0, 11) == 0)
				program_random();
			rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 48)
				: $urandom_range(1, len_mirror + 6);
			for (int i = 0; i < rlen; i++)
				rbytes[i] = filler_byte(amode);
			if (rlen >= len_mirror && $urandom_range(0, 9) < 6) begin
				ofs = $urandom_range(0, rlen - len_mirror);
				for (int k = 0; k < len_mirror; k++)
					if (cmp_mirror[k])
						rbytes[ofs + k] = pat_mirror[8*k +: 8];
				if ($urandom_range(0, 3) == 0) begin
					j = $urandom_range(0, len_mirror - 1);
					if (cmp_mirror[j])
						rbytes[ofs + j] ^= 8'(1 << $urandom_range(0, 7));
				end
			end
			base = ($urandom_range(0, 7) == 0)
				? mbps_pkg::ADDR_W'('1) - mbps_pkg::ADDR_W'($urandom_range(0, 20))
				: mbps_pkg::ADDR_W'(rand64());
			for (int i = 0; i < rlen; i++) begin
				a = base + mbps_pkg::ADDR_W'(i);
				if ($urandom_range(0, 49) == 0)
					base = base + mbps_pkg::ADDR_W'(rand64());
				if (i == 0)
					rs = (r == 0) ? 1'($urandom_range(0, 1)) : 1'b1;
				else
					rs = ($urandom_range(0, 59) == 0);
				se = (r == nreg - 1) && (i == rlen - 1);
				push_byte(rbytes[i], a, rs, se);
			end
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_write          <= 1'b0;
		cfg_index          <= mbps_pkg::REG_PAT_LO;
		cfg_data           <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.data_byte    <= 8'h00;
		in_ch.byte_address <= '0;
		in_ch.region_start <= 1'b0;
		in_ch.scan_end     <= 1'b0;
		pat_mirror = '0;
		cmp_mirror = '0;
		len_mirror = 1;
		burst_left = 0;
		bytes_sent = 0;
		idle_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern: length one, all wildcard
		push_byte(8'h00, 48'h0, 1'b0, 1'b0);
		push_byte(8'hFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);

		// wildcard in the middle, match address wraps
		program_regs(64'h3322_11FF_00EF_CDAB, 64'hFFEE_DDCC_BBAA_9988, 64'hFFFB, 64'd4);
		push_byte(8'hAB, 48'hFFFF_FFFF_FFFE, 1'b1, 1'b0);
		push_byte(8'hCD, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0);
		push_byte(8'h5A, 48'h0, 1'b0, 1'b0);
		push_byte(8'h00, 48'h1, 1'b0, 1'b0);
		push_byte(8'h12, 48'h2, 1'b0, 1'b0);
		push_byte(8'h34, 48'h3, 1'b0, 1'b1);

		// region start breaks a partial match; next match lands on the scan end
		push_byte(8'hAB, 48'h100, 1'b1, 1'b0);
		push_byte(8'hCD, 48'h101, 1'b0, 1'b0);
		push_byte(8'h77, 48'h102, 1'b1, 1'b0);
		push_byte(8'h00, 48'h103, 1'b0, 1'b0);
		push_byte(8'hAB, 48'h200, 1'b1, 1'b0);
		push_byte(8'hCD, 48'h201, 1'b0, 1'b0);
		push_byte(8'h99, 48'h202, 1'b0, 1'b0);
		push_byte(8'h00, 48'h203, 1'b0, 1'b1);

		// scan too short to match
		push_byte(8'h01, 48'h300, 1'b0, 1'b0);
		push_byte(8'h02, 48'h301, 1'b0, 1'b0);
		push_byte(8'h03, 48'h302, 1'b0, 1'b1);

		// length code zero behaves as one
		program_regs(64'h0000_0000_0000_00FF, 64'h0, 64'h1, 64'd0);
		push_byte(8'h00, 48'h400, 1'b0, 1'b0);
		push_byte(8'hFF, 48'h401, 1'b0, 1'b0);
		push_byte(8'h00, 48'h402, 1'b0, 1'b1);

		// oversize length clamps, then a change in mid scan
		program_regs('1, '1, 64'hFFFF, 64'd31);
		push_byte(8'hFF, 48'h500, 1'b1, 1'b0);
		push_byte(8'hFF, 48'h501, 1'b0, 1'b0);
		program_regs('1, 64'h0, 64'h3, 64'd2);
		push_byte(8'hFF, 48'h502, 1'b0, 1'b1);

		while (bytes_sent < ITEM_TARGET) begin
			program_random();
			repeat ($urandom_range(5, 25)) run_scan();
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
